// ===== sv/detector_pixel_to_grid_macros.svh =====
// Assertion macros for the pixel-to-grid block.
// Define ASSERT_OFF to compile the checks out.
`ifndef DETECTOR_PIXEL_TO_GRID_MACROS_SVH
`define DETECTOR_PIXEL_TO_GRID_MACROS_SVH
`ifndef ASSERT_OFF
// Check on every clock edge outside reset
`define DPG_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dpg: assertion failed");
// Check on every clock edge, reset included
`define DPG_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("dpg: reset check failed");
`else
`define DPG_ASSERT(name, prop)
`define DPG_ASSERT_RST(name, prop)
`endif
`endif

// ===== sv/dpg_pkg.sv =====
`default_nettype none

package dpg_pkg;

  // Default parameter values
  localparam int PIXEL_BITS_DEF = 12;
  localparam int COEF_BITS_DEF  = 32;
  localparam int COEF_COUNT_DEF = 21;

  // Field widths of the channels
  localparam int PIX_W  = 12;
  localparam int IDX_W  = 5;
  localparam int VAL_W  = 32;
  localparam int GRID_W = 32;

  // Coefficient slot bases
  localparam int A_BASE = 0;
  localparam int C_BASE = 6;
  localparam int M_BASE = 9;
  localparam int G_BASE = 18;

  // Ray and normalization widths
  localparam int V_W    = 64;
  localparam int WIDE_W = 68;
  localparam int MAG_W  = 63;
  localparam int POS_W  = 6;
  localparam int NW     = 30;
  localparam int SQR_W  = 2 * NW;
  localparam int SUM_W  = SQR_W + 2;
  localparam int RES_W  = SUM_W + 1;
  localparam int Q_W    = NW + 1;
  localparam int REM_W  = NW + 30 + 1;
  localparam int SQ_N   = SUM_W / 2;
  localparam int DV_N   = Q_W;
  localparam int NORM_LAT = 5 + SQ_N + DV_N;

  // Request kinds
  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_LOAD  = 1'b1
  } req_e;

  // Direction status handed from normalization to the grid stage
  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } dir_ctl_t;

  localparam logic signed [WIDE_W-1:0] SAT_HI =
    {{(WIDE_W - V_W + 1){1'b0}}, {(V_W - 1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI;

  // Clamp a wide sum to +-(2^63-1)
  function automatic logic signed [V_W-1:0] sat_v(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] y;
    if (x > SAT_HI) begin
      y = SAT_HI;
    end else if (x < SAT_LO) begin
      y = SAT_LO;
    end else begin
      y = x;
    end
    return y[V_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/dpg_if.sv =====
`default_nettype none

// Request channel: pixel transforms and coefficient loads
interface dpg_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic        [dpg_pkg::PIX_W-1:0]  pixel_x;
  logic        [dpg_pkg::PIX_W-1:0]  pixel_y;
  logic        [dpg_pkg::IDX_W-1:0]  coef_index;
  logic signed [dpg_pkg::VAL_W-1:0]  coef_value;

  modport source (output valid, req_type, pixel_x, pixel_y, coef_index, coef_value,
                  input ready);
  modport sink   (input valid, req_type, pixel_x, pixel_y, coef_index, coef_value,
                  output ready);
endinterface

// Result channel: grid coordinates
interface dpg_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [dpg_pkg::GRID_W-1:0] grid_x;
  logic signed [dpg_pkg::GRID_W-1:0] grid_y;
  logic signed [dpg_pkg::GRID_W-1:0] grid_z;
  logic                              invalid;

  modport source (output valid, grid_x, grid_y, grid_z, invalid, input ready);
  modport sink   (input valid, grid_x, grid_y, grid_z, invalid, output ready);
endinterface

`default_nettype wire

// ===== sv/dpg_ray.sv =====
`default_nettype none

module dpg_ray #(
  parameter int PIXEL_BITS = dpg_pkg::PIXEL_BITS_DEF,
  parameter int COEF_BITS  = dpg_pkg::COEF_BITS_DEF,
  parameter int COEF_COUNT = dpg_pkg::COEF_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic        [PIXEL_BITS-1:0]     pixel_x_i,
  input  logic        [PIXEL_BITS-1:0]     pixel_y_i,
  input  logic signed [COEF_BITS-1:0]      coef_i [COEF_COUNT],
  output logic                             valid_o,
  output logic signed [dpg_pkg::V_W-1:0]   v_o [3],
  output logic                             busy_o
);

  localparam int PW = COEF_BITS + PIXEL_BITS + 1;
  localparam int WW = dpg_pkg::WIDE_W;

  logic [2:0] vld_q;
  logic signed [PIXEL_BITS:0]      sx, sy;
  logic signed [PW-1:0]            prod_d [6];
  logic signed [PW-1:0]            prod_q [6];
  logic signed [dpg_pkg::V_W-1:0]  t_d [3];
  logic signed [dpg_pkg::V_W-1:0]  t_q [3];
  logic signed [dpg_pkg::V_W-1:0]  v_d [3];
  logic signed [dpg_pkg::V_W-1:0]  v_q [3];

  assign sx = $signed({1'b0, pixel_x_i});
  assign sy = $signed({1'b0, pixel_y_i});

  // Multiply each row of A by the pixel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[2*i]   = PW'(coef_i[dpg_pkg::A_BASE + 2*i]) * PW'(sx);
      prod_d[2*i+1] = PW'(coef_i[dpg_pkg::A_BASE + 2*i + 1]) * PW'(sy);
    end
  end

  // Saturating row sums, then add the offset c
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_d[i] = dpg_pkg::sat_v(WW'(prod_q[2*i]) + WW'(prod_q[2*i+1]));
      v_d[i] = dpg_pkg::sat_v(WW'(t_q[i]) + WW'(coef_i[dpg_pkg::C_BASE + i]));
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      t_q    <= t_d;
      v_q    <= v_d;
    end
  end

  assign valid_o = vld_q[2];
  assign v_o     = v_q;
  assign busy_o  = |vld_q;

endmodule

`default_nettype wire

// ===== sv/dpg_norm.sv =====
`default_nettype none

module dpg_norm (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [dpg_pkg::V_W-1:0]  v_i [3],
  output dpg_pkg::dir_ctl_t               ctl_o,
  output logic [dpg_pkg::Q_W-1:0]         q_o [3],
  output logic                            busy_o
);

  localparam int LAT   = dpg_pkg::NORM_LAT;
  localparam int NW    = dpg_pkg::NW;
  localparam int SQ_N  = dpg_pkg::SQ_N;
  localparam int DV_N  = dpg_pkg::DV_N;
  localparam int WN_N  = 3 + SQ_N;
  localparam int MAG_W = dpg_pkg::MAG_W;
  localparam int RES_W = dpg_pkg::RES_W;
  localparam int SUM_W = dpg_pkg::SUM_W;
  localparam int REM_W = dpg_pkg::REM_W;
  localparam int Q_W   = dpg_pkg::Q_W;
  localparam int POS_W = dpg_pkg::POS_W;

  logic [LAT-1:0] vld_q;
  logic [2:0]     neg_d;
  logic [2:0]     neg_q  [LAT];
  logic           zero_d;
  logic           zero_q [LAT-1];

  logic [dpg_pkg::V_W-1:0] vabs [3];
  logic [MAG_W-1:0] mag_d [3];
  logic [MAG_W-1:0] mag1_q [3];
  logic [MAG_W-1:0] mag2_q [3];
  logic [MAG_W-1:0] or_d, or1_q;
  logic [POS_W-1:0] pos_d, pos2_q;
  logic [MAG_W-1:0] sh;
  logic [NW-1:0]    wn_d [3];
  logic [NW-1:0]    wn_q [WN_N][3];
  logic [dpg_pkg::SQR_W-1:0] sq_q [3];
  logic [SUM_W-1:0] s_q;

  logic [SUM_W-1:0] sn_in;
  logic [RES_W-1:0] sr_in, trial;
  logic [SUM_W-1:0] sn_d [SQ_N];
  logic [RES_W-1:0] sr_d [SQ_N];
  logic [SUM_W-1:0] sn_q [SQ_N];
  logic [RES_W-1:0] sr_q [SQ_N];

  logic [Q_W-1:0]   r_fin, dr_in;
  logic [REM_W-1:0] rem_in;
  logic [Q_W-1:0]   q_in;
  logic [REM_W:0]   dvs;
  logic [Q_W-1:0]   dr_d [DV_N];
  logic [Q_W-1:0]   dr_q [DV_N];
  logic [REM_W-1:0] rem_d [DV_N][3];
  logic [REM_W-1:0] rem_q [DV_N][3];
  logic [Q_W-1:0]   qd_d [DV_N][3];
  logic [Q_W-1:0]   qd_q [DV_N][3];

  // Take magnitudes and a common OR for the leading-one search
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = v_i[i][dpg_pkg::V_W-1];
      vabs[i]  = neg_d[i] ? (dpg_pkg::V_W'(0) - v_i[i]) : v_i[i];
      mag_d[i] = vabs[i][MAG_W-1:0];
    end
    or_d = mag_d[0] | mag_d[1] | mag_d[2];
  end

  // Find the leading one of the largest magnitude
  always_comb begin
    pos_d = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (or1_q[b]) begin
        pos_d = POS_W'(b);
      end
    end
    zero_d = (or1_q == '0);
  end

  // Scale so the largest magnitude lies in [2^29, 2^30)
  always_comb begin
    sh = '0;
    for (int i = 0; i < 3; i++) begin
      if (pos2_q >= POS_W'(NW)) begin
        sh = mag2_q[i] >> (pos2_q - POS_W'(NW - 1));
      end else begin
        sh = mag2_q[i] << (POS_W'(NW - 1) - pos2_q);
      end
      wn_d[i] = sh[NW-1:0];
    end
  end

  // Integer square root, one result bit per stage
  always_comb begin
    sn_in = '0;
    sr_in = '0;
    trial = '0;
    for (int j = 0; j < SQ_N; j++) begin
      if (j == 0) begin
        sn_in = s_q;
        sr_in = '0;
      end else begin
        sn_in = sn_q[j-1];
        sr_in = sr_q[j-1];
      end
      trial = sr_in + (RES_W'(1) << (2 * (SQ_N - 1 - j)));
      if ({1'b0, sn_in} >= trial) begin
        sn_d[j] = sn_in - trial[SUM_W-1:0];
        sr_d[j] = (sr_in >> 1) + (RES_W'(1) << (2 * (SQ_N - 1 - j)));
      end else begin
        sn_d[j] = sn_in;
        sr_d[j] = sr_in >> 1;
      end
    end
  end

  assign r_fin = sr_q[SQ_N-1][Q_W-1:0];

  // Restoring division u = round(w * 2^30 / r), one quotient bit per stage
  always_comb begin
    rem_in = '0;
    q_in   = '0;
    dr_in  = '0;
    dvs    = '0;
    for (int j = 0; j < DV_N; j++) begin
      dr_in = (j == 0) ? r_fin : dr_q[j-1];
      dr_d[j] = dr_in;
      dvs = (REM_W + 1)'(dr_in) << (DV_N - 1 - j);
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          rem_in = (REM_W'(wn_q[WN_N-1][i]) << 30) + REM_W'(r_fin >> 1);
          q_in   = '0;
        end else begin
          rem_in = rem_q[j-1][i];
          q_in   = qd_q[j-1][i];
        end
        if ({1'b0, rem_in} >= dvs) begin
          rem_d[j][i] = rem_in - dvs[REM_W-1:0];
          qd_d[j][i]  = q_in | (Q_W'(1) << (DV_N - 1 - j));
        end else begin
          rem_d[j][i] = rem_in;
          qd_d[j][i]  = q_in;
        end
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  // Advance payload and side status
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= neg_d;
      for (int k = 1; k < LAT; k++) neg_q[k] <= neg_q[k-1];
      zero_q[0] <= zero_d;
      for (int k = 1; k < LAT - 1; k++) zero_q[k] <= zero_q[k-1];
      mag1_q <= mag_d;
      or1_q  <= or_d;
      mag2_q <= mag1_q;
      pos2_q <= pos_d;
      wn_q[0] <= wn_d;
      for (int k = 1; k < WN_N; k++) wn_q[k] <= wn_q[k-1];
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= dpg_pkg::SQR_W'(wn_q[0][i]) * dpg_pkg::SQR_W'(wn_q[0][i]);
      end
      s_q  <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      sn_q <= sn_d;
      sr_q <= sr_d;
      dr_q <= dr_d;
      rem_q <= rem_d;
      qd_q  <= qd_d;
    end
  end

  assign ctl_o.valid = vld_q[LAT-1];
  assign ctl_o.zero  = zero_q[LAT-2];
  assign ctl_o.neg   = neg_q[LAT-1];
  assign q_o         = qd_q[DV_N-1];
  assign busy_o      = |vld_q;

endmodule

`default_nettype wire

// ===== sv/dpg_grid.sv =====
`default_nettype none

module dpg_grid #(
  parameter int COEF_BITS  = dpg_pkg::COEF_BITS_DEF,
  parameter int COEF_COUNT = dpg_pkg::COEF_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  dpg_pkg::dir_ctl_t                  ctl_i,
  input  logic [dpg_pkg::Q_W-1:0]            q_i [3],
  input  logic signed [COEF_BITS-1:0]        coef_i [COEF_COUNT],
  output logic                               valid_o,
  output logic signed [dpg_pkg::GRID_W-1:0]  grid_o [3],
  output logic                               invalid_o,
  output logic                               busy_o
);

  localparam int CB  = COEF_BITS;
  localparam int PRW = CB + dpg_pkg::Q_W;
  localparam int TW  = CB + 2;
  localparam int AW  = CB + 4;
  localparam int GW  = dpg_pkg::GRID_W;
  localparam logic signed [63:0] G_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] G_LO = -64'sh0000_0000_8000_0000;

  logic [3:0] vld_q;
  logic       zero_q [4];

  logic [CB-1:0]         mc_abs [9];
  logic [PRW-1:0]        prod_d [9];
  logic [PRW-1:0]        prod_q [9];
  logic                  pneg_d [9];
  logic                  pneg_q [9];
  logic [PRW:0]          rnd_full [9];
  logic [TW-1:0]         rnd_w [9];
  logic signed [TW-1:0]  term_d [9];
  logic signed [TW-1:0]  term_q [9];
  logic signed [AW-1:0]  acc_d [3];
  logic signed [AW-1:0]  acc_q [3];
  logic signed [AW-1:0]  rsh [3];
  logic signed [63:0]    rwide [3];
  logic signed [GW-1:0]  grid_d [3];
  logic signed [GW-1:0]  grid_q [3];

  // Multiply |M| by |u|
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mc_abs[3*i+j] = coef_i[dpg_pkg::M_BASE + 3*i + j][CB-1]
                        ? (CB'(0) - CB'(coef_i[dpg_pkg::M_BASE + 3*i + j]))
                        : CB'(coef_i[dpg_pkg::M_BASE + 3*i + j]);
        prod_d[3*i+j] = PRW'(mc_abs[3*i+j]) * PRW'(q_i[j]);
        pneg_d[3*i+j] = coef_i[dpg_pkg::M_BASE + 3*i + j][CB-1] ^ ctl_i.neg[j];
      end
    end
  end

  // Round each product to Q.24, then apply the sign
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rnd_full[k] = (PRW + 1)'(prod_q[k]) + ((PRW + 1)'(1) << 29);
      rnd_w[k]    = rnd_full[k][PRW:30];
      term_d[k]   = pneg_q[k] ? -$signed(rnd_w[k]) : $signed(rnd_w[k]);
    end
  end

  // Sum the row with the offset g0
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = AW'(coef_i[dpg_pkg::G_BASE + i]) + AW'(term_q[3*i])
               + AW'(term_q[3*i+1]) + AW'(term_q[3*i+2]);
    end
  end

  // Round to Q.16 toward +infinity on ties and clamp to 32 bits; a zero ray gives zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsh[i]   = (acc_q[i] + AW'(128)) >>> 8;
      rwide[i] = 64'(rsh[i]);
      if (zero_q[2]) begin
        grid_d[i] = '0;
      end else if (rwide[i] > G_HI) begin
        grid_d[i] = G_HI[GW-1:0];
      end else if (rwide[i] < G_LO) begin
        grid_d[i] = G_LO[GW-1:0];
      end else begin
        grid_d[i] = rwide[i][GW-1:0];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], ctl_i.valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= ctl_i.zero;
      for (int k = 1; k < 4; k++) zero_q[k] <= zero_q[k-1];
      prod_q <= prod_d;
      pneg_q <= pneg_d;
      term_q <= term_d;
      acc_q  <= acc_d;
      grid_q <= grid_d;
    end
  end

  assign valid_o   = vld_q[3];
  assign invalid_o = zero_q[3];
  assign grid_o    = grid_q;
  assign busy_o    = |vld_q;

endmodule

`default_nettype wire

// ===== sv/detector_pixel_to_grid.sv =====
// A pixel's result is offered on res_o from the last of 75 register stages, the first loaded
// at the transfer: 3 ray, 67 normalization, 4 grid, output register. Throughput: one pixel
// per cycle while the output register is not held full; sqrt and divider are pipelined.
// A coefficient load waits until no pixel is in flight, then is written at its transfer.
// Reset (rst_ni low, asynchronous) clears all valid bits and the coefficient table.
`default_nettype none
`include "detector_pixel_to_grid_macros.svh"

module detector_pixel_to_grid #(
  parameter int PIXEL_BITS = dpg_pkg::PIXEL_BITS_DEF,
  parameter int COEF_BITS  = dpg_pkg::COEF_BITS_DEF,
  parameter int COEF_COUNT = dpg_pkg::COEF_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dpg_req_if.sink    req_i,
  dpg_res_if.source  res_o
);

  logic adv, busy, req_xfer, is_load;
  logic busy_ray, busy_norm, busy_grid;
  logic signed [COEF_BITS-1:0] coef_q [COEF_COUNT];
  logic [PIXEL_BITS-1:0] px, py;

  logic                           ray_valid;
  logic signed [dpg_pkg::V_W-1:0] ray_v [3];
  dpg_pkg::dir_ctl_t              dir_ctl;
  logic [dpg_pkg::Q_W-1:0]        dir_q [3];

  logic                              grid_valid, grid_invalid;
  logic signed [dpg_pkg::GRID_W-1:0] grid_val [3];

  logic                              res_vld_q;
  logic signed [dpg_pkg::GRID_W-1:0] res_grid_q [3];
  logic                              res_inv_q;
  logic                              res_all_zero;

  // Stall the whole pipeline only when the output register is full and held
  assign adv      = !res_vld_q || res_o.ready;
  assign busy     = busy_ray || busy_norm || busy_grid;
  assign is_load  = (req_i.req_type == dpg_pkg::REQ_LOAD);
  assign req_i.ready = adv && !(is_load && busy);
  assign req_xfer = req_i.valid && req_i.ready;
  assign px = PIXEL_BITS'(req_i.pixel_x);
  assign py = PIXEL_BITS'(req_i.pixel_y);

  // Write one coefficient on a load transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < COEF_COUNT; k++) coef_q[k] <= '0;
    end else if (req_xfer && is_load) begin
      for (int k = 0; k < COEF_COUNT; k++) begin
        if (req_i.coef_index == dpg_pkg::IDX_W'(k)) begin
          coef_q[k] <= COEF_BITS'(req_i.coef_value);
        end
      end
    end
  end

  dpg_ray #(
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS),
    .COEF_COUNT (COEF_COUNT)
  ) u_ray (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (req_xfer && !is_load),
    .pixel_x_i (px),
    .pixel_y_i (py),
    .coef_i    (coef_q),
    .valid_o   (ray_valid),
    .v_o       (ray_v),
    .busy_o    (busy_ray)
  );

  dpg_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (ray_valid),
    .v_i     (ray_v),
    .ctl_o   (dir_ctl),
    .q_o     (dir_q),
    .busy_o  (busy_norm)
  );

  dpg_grid #(
    .COEF_BITS  (COEF_BITS),
    .COEF_COUNT (COEF_COUNT)
  ) u_grid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .ctl_i     (dir_ctl),
    .q_i       (dir_q),
    .coef_i    (coef_q),
    .valid_o   (grid_valid),
    .grid_o    (grid_val),
    .invalid_o (grid_invalid),
    .busy_o    (busy_grid)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= grid_valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_grid_q <= grid_val;
      res_inv_q  <= grid_invalid;
    end
  end

  assign res_o.valid   = res_vld_q;
  assign res_o.grid_x  = res_grid_q[0];
  assign res_o.grid_y  = res_grid_q[1];
  assign res_o.grid_z  = res_grid_q[2];
  assign res_o.invalid = res_inv_q;

  assign res_all_zero = (res_grid_q[0] == '0) && (res_grid_q[1] == '0)
                        && (res_grid_q[2] == '0);

  `DPG_ASSERT(a_load_when_idle, req_xfer && is_load |-> !busy)
  `DPG_ASSERT(a_grid_reaches_out, grid_valid && adv |=> res_o.valid)
  `DPG_ASSERT(a_zero_ray_clears, res_o.valid && res_o.invalid |-> res_all_zero)
  `DPG_ASSERT_RST(a_reset_quiet, !rst_ni |-> !res_o.valid && !busy)

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  typedef struct packed {
    logic signed [dpg_pkg::GRID_W-1:0] gx;
    logic signed [dpg_pkg::GRID_W-1:0] gy;
    logic signed [dpg_pkg::GRID_W-1:0] gz;
    logic                              inv;
  } grid_res_t;

  typedef struct {
    dpg_pkg::req_e                    kind;
    logic [dpg_pkg::PIX_W-1:0]        x;
    logic [dpg_pkg::PIX_W-1:0]        y;
    logic [dpg_pkg::IDX_W-1:0]        idx;
    logic signed [dpg_pkg::VAL_W-1:0] val;
    bit                               typed;
    grid_res_t                        want;
  } stim_row_t;

  localparam logic signed [dpg_pkg::VAL_W-1:0] ONE_Q24 = 32'sh0100_0000;
  localparam logic signed [dpg_pkg::VAL_W-1:0] MAX_Q24 = 32'sh7fff_ffff;
  localparam logic signed [dpg_pkg::VAL_W-1:0] MIN_Q24 = 32'sh8000_0000;
  localparam grid_res_t ZERO_RAY = '{gx: '0, gy: '0, gz: '0, inv: 1'b1};
  localparam grid_res_t UNIT_Z   = '{gx: '0, gy: '0, gz: 32'sd65536, inv: 1'b0};

  logic clk_i;
  logic rst_ni;

  dpg_req_if req_bus ();
  dpg_res_if res_bus ();

  detector_pixel_to_grid dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  longint    coef_q [dpg_pkg::COEF_COUNT_DEF];
  grid_res_t grid_expected [$];
  int        mismatch_cnt;
  int        items_sent;
  int        rx_stall;
  bit        quiet;
  bit        hold_off;
  bit        stim_done;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Report one mismatch
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_cnt++;
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
  endtask

  // Clamp a signed 64-bit ray sum to +-(2^63-1)
  function automatic longint ray_sum(input longint a, input longint b);
    logic signed [64:0] w;
    w = a;
    w = w + b;
    if (w > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
    if (w < -65'sh0_7fff_ffff_ffff_ffff) return -64'sh7fff_ffff_ffff_ffff;
    return longint'(w[63:0]);
  endfunction

  // Compute the grid point of one pixel from the current coefficients
  function automatic grid_res_t predict_grid(input logic [dpg_pkg::PIX_W-1:0] x,
                                             input logic [dpg_pkg::PIX_W-1:0] y);
    longint          ray [3];
    longint          dir [3];
    longint unsigned wm [3];
    longint unsigned mx, s, r, q, p, bit_v, n, hi, lo, rem, um;
    longint          acc, rv, mc;
    logic [63:0]     b;
    int              rs, ls;
    grid_res_t       o;
    rs = 0;
    ls = 0;
    for (int i = 0; i < 3; i++) begin
      ray[i] = ray_sum(coef_q[dpg_pkg::A_BASE + 2 * i] * longint'(x),
                       coef_q[dpg_pkg::A_BASE + 2 * i + 1] * longint'(y));
      ray[i] = ray_sum(ray[i], coef_q[dpg_pkg::C_BASE + i]);
      wm[i] = ray[i] < 0 ? -ray[i] : ray[i];
    end
    mx = wm[0];
    if (wm[1] > mx) mx = wm[1];
    if (wm[2] > mx) mx = wm[2];
    if (mx == 0) return ZERO_RAY;
    while (mx >= 64'd1 << 30) begin
      mx >>= 1;
      rs++;
    end
    while (mx < 64'd1 << 29) begin
      mx <<= 1;
      ls++;
    end
    s = 0;
    for (int i = 0; i < 3; i++) begin
      wm[i] = (wm[i] >> rs) << ls;
      s += wm[i] * wm[i];
    end
    // Integer square root, bit by bit
    n = s;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      q = ((wm[i] << 30) + (r >> 1)) / r;
      dir[i] = ray[i] < 0 ? -longint'(q) : longint'(q);
    end
    // Rotate into the grid, round to Q16.16 and clamp
    for (int i = 0; i < 3; i++) begin
      acc = coef_q[dpg_pkg::G_BASE + i];
      for (int j = 0; j < 3; j++) begin
        mc = coef_q[dpg_pkg::M_BASE + 3 * i + j];
        um = dir[j] < 0 ? -dir[j] : dir[j];
        hi = (mc < 0 ? -mc : mc) * (um >> 16);
        lo = (mc < 0 ? -mc : mc) * (um & 64'hffff);
        rem = ((hi & 64'h3fff) << 16) + lo + (64'd1 << 29);
        p = (hi >> 14) + (rem >> 30);
        acc += ((mc < 0) != (dir[j] < 0)) ? -longint'(p) : longint'(p);
      end
      b = acc + 64'h4000_0000_0000_0000 + 64'd128;
      rv = longint'(b >> 8) - (64'sd1 <<< 54);
      if (rv > 64'sh7fff_ffff) rv = 64'sh7fff_ffff;
      if (rv < -64'sh8000_0000) rv = -64'sh8000_0000;
      case (i)
        0: o.gx = rv[31:0];
        1: o.gy = rv[31:0];
        default: o.gz = rv[31:0];
      endcase
    end
    o.inv = 1'b0;
    return o;
  endfunction

  // Offer one request, hold it until the transfer, then log its effect
  task automatic send_req(input stim_row_t row);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap != 0) begin
      req_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    req_bus.req_type   = row.kind;
    req_bus.pixel_x    = row.x;
    req_bus.pixel_y    = row.y;
    req_bus.coef_index = row.idx;
    req_bus.coef_value = row.val;
    req_bus.valid      = 1'b1;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    items_sent++;
    if (row.kind == dpg_pkg::REQ_LOAD) begin
      if (row.idx < dpg_pkg::COEF_COUNT_DEF) coef_q[row.idx] = longint'(row.val);
    end else begin
      grid_expected.push_back(row.typed ? row.want : predict_grid(row.x, row.y));
    end
  endtask

  function automatic stim_row_t load_row(input int idx,
                                         input logic signed [dpg_pkg::VAL_W-1:0] val);
    stim_row_t row;
    row = '{kind: dpg_pkg::REQ_LOAD, x: '0, y: '0, idx: dpg_pkg::IDX_W'(idx), val: val,
            typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t pixel_row(input int x, input int y, input bit typed,
                                          input grid_res_t want);
    stim_row_t row;
    row = '{kind: dpg_pkg::REQ_PIXEL, x: dpg_pkg::PIX_W'(x), y: dpg_pkg::PIX_W'(y),
            idx: '0, val: '0, typed: typed, want: want};
    return row;
  endfunction

  // Random coefficient: mostly within +-2 (Q.24), sometimes anywhere
  function automatic logic signed [dpg_pkg::VAL_W-1:0] rand_coef();
    if ($urandom_range(0, 9) < 7) begin
      return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    end
    return $urandom;
  endfunction

  // Stimulus
  initial begin
    stim_row_t table_rows [$];
    stim_row_t row;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = dpg_pkg::REQ_PIXEL;
    req_bus.pixel_x    = '0;
    req_bus.pixel_y    = '0;
    req_bus.coef_index = '0;
    req_bus.coef_value = '0;
    foreach (coef_q[i]) coef_q[i] = 0;
    mismatch_cnt = 0;
    items_sent   = 0;
    quiet        = 1'b0;
    stim_done    = 1'b0;
    rst_ni       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: cleared table, unit axes, extremes, ignored slot, zero ray
    table_rows.push_back(pixel_row(0, 0, 1'b1, ZERO_RAY));
    table_rows.push_back(load_row(dpg_pkg::A_BASE, ONE_Q24));
    table_rows.push_back(load_row(dpg_pkg::A_BASE + 3, ONE_Q24));
    table_rows.push_back(load_row(dpg_pkg::C_BASE + 2, ONE_Q24));
    table_rows.push_back(load_row(dpg_pkg::M_BASE, ONE_Q24));
    table_rows.push_back(load_row(dpg_pkg::M_BASE + 4, ONE_Q24));
    table_rows.push_back(load_row(dpg_pkg::M_BASE + 8, ONE_Q24));
    table_rows.push_back(pixel_row(0, 0, 1'b1, UNIT_Z));
    table_rows.push_back(pixel_row(4095, 4095, 1'b0, '0));
    table_rows.push_back(pixel_row(4095, 0, 1'b0, '0));
    table_rows.push_back(load_row(dpg_pkg::G_BASE, MAX_Q24));
    table_rows.push_back(pixel_row(0, 0, 1'b0, '0));
    table_rows.push_back(load_row(dpg_pkg::G_BASE + 1, MIN_Q24));
    table_rows.push_back(load_row(31, 32'sh1234_5678));
    table_rows.push_back(load_row(dpg_pkg::A_BASE + 1, MAX_Q24));
    table_rows.push_back(load_row(dpg_pkg::A_BASE + 2, MIN_Q24));
    table_rows.push_back(load_row(dpg_pkg::A_BASE + 4, MAX_Q24));
    table_rows.push_back(load_row(dpg_pkg::A_BASE + 5, MIN_Q24));
    table_rows.push_back(pixel_row(4095, 4095, 1'b0, '0));
    table_rows.push_back(pixel_row(1, 2048, 1'b0, '0));
    table_rows.push_back(load_row(dpg_pkg::C_BASE + 2, '0));
    table_rows.push_back(pixel_row(0, 0, 1'b1, ZERO_RAY));
    table_rows.push_back(load_row(dpg_pkg::C_BASE + 2, MIN_Q24));
    table_rows.push_back(pixel_row(0, 0, 1'b0, '0));
    foreach (table_rows[i]) send_req(table_rows[i]);

    // Random: reload the table now and then, mostly stream pixels
    for (int phase = 0; phase < 5; phase++) begin
      quiet = (phase == 2);
      for (int k = 0; k < 150; k++) begin
        if ($urandom_range(0, 99) < 12) begin
          if ($urandom_range(0, 19) == 0) row = load_row($urandom_range(21, 31), $urandom);
          else row = load_row($urandom_range(0, dpg_pkg::COEF_COUNT_DEF - 1), rand_coef());
        end else begin
          row = pixel_row($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, '0);
          if ($urandom_range(0, 29) == 0) row.x = '0;
        end
        send_req(row);
      end
    end
    @(negedge clk_i);
    req_bus.valid = 1'b0;
    stim_done = 1'b1;
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    wait (items_sent >= 350);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Result ready with random stalls
  initial begin
    res_bus.ready = 1'b0;
    rx_stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        res_bus.ready = 1'b0;
      end else if (rx_stall > 0) begin
        res_bus.ready = 1'b0;
        rx_stall--;
      end else begin
        res_bus.ready = 1'b1;
      end
    end
  end

  // Compare each transfer with the oldest expected grid point
  always @(posedge clk_i) begin
    grid_res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      rx_stall = quiet ? 0 : $urandom_range(0, 9);
      if (grid_expected.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = grid_expected.pop_front();
        if (res_bus.grid_x !== want.gx) report_mismatch("grid_x", res_bus.grid_x, want.gx);
        if (res_bus.grid_y !== want.gy) report_mismatch("grid_y", res_bus.grid_y, want.gy);
        if (res_bus.grid_z !== want.gz) report_mismatch("grid_z", res_bus.grid_z, want.gz);
        if (res_bus.invalid !== want.inv) report_mismatch("invalid", res_bus.invalid, want.inv);
      end
    end
  end

  // Drain, then judge
  initial begin
    wait (stim_done && grid_expected.size() == 0);
    repeat (150) @(posedge clk_i);
    if (grid_expected.size() != 0) report_mismatch("results left over", grid_expected.size(), 0);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/dpg_pkg.sv
sv/dpg_if.sv
sv/dpg_ray.sv
sv/dpg_norm.sv
sv/dpg_grid.sv
sv/detector_pixel_to_grid.sv
tb/sv/tb_top.sv
